// ===== design/formula_char_tokenizer_assert.svh =====
// Assertion macros for the formula character tokenizer.
`ifndef FORMULA_CHAR_TOKENIZER_ASSERT_SVH
`define FORMULA_CHAR_TOKENIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/fct_pkg.sv =====
// Package: constants, types and character classes of the formula tokenizer.
`timescale 1ns / 1ps
package fct_pkg;
    localparam int MaxTextLength   = 4096;
    localparam int ScopeStackDepth = 16;
    localparam int PosW            = 13;
    localparam int StartW          = 12;
    localparam int KindW           = 5;
    localparam int ResultCount     = 3;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_NUM  = 3'd1,
        MODE_NAME = 3'd2,
        MODE_STR  = 3'd3,
        MODE_ERR  = 3'd4
    } t_mode;

    localparam logic [KindW-1:0] K_NUMBER    = 5'd0;
    localparam logic [KindW-1:0] K_NAME      = 5'd1;
    localparam logic [KindW-1:0] K_STRING    = 5'd2;
    localparam logic [KindW-1:0] K_ERROR     = 5'd3;
    localparam logic [KindW-1:0] K_SEP       = 5'd17;
    localparam logic [KindW-1:0] K_ROWSEP    = 5'd18;
    localparam logic [KindW-1:0] K_END       = 5'd19;
    localparam logic [KindW-1:0] K_BAD_ERROR = 5'd20;
    localparam logic [KindW-1:0] K_OVERFLOW  = 5'd21;
    localparam logic [KindW-1:0] K_NONE      = 5'd0;

    localparam logic [1:0] REG_ARG = 2'd0;
    localparam logic [1:0] REG_ROW = 2'd1;
    localparam logic [1:0] REG_DEC = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // One emitted token, plus its valid flag.
    typedef struct packed {
        logic              vld;
        logic [KindW-1:0]  kind;
        logic [StartW-1:0] start;
        logic [PosW-1:0]   len;
    } t_tok;

    // Operator kind for a byte, or zero if it is no operator.
    function automatic logic [KindW-1:0] op_kind(input logic [7:0] c);
        logic [KindW-1:0] k;
        k = '0;
        case (c)
            8'h26: k = 5'd4;
            8'h28: k = 5'd5;
            8'h29: k = 5'd6;
            8'h2A: k = 5'd7;
            8'h2B: k = 5'd8;
            8'h2D: k = 5'd9;
            8'h2F: k = 5'd10;
            8'h3C: k = 5'd11;
            8'h3D: k = 5'd12;
            8'h3E: k = 5'd13;
            8'h5E: k = 5'd14;
            8'h7B: k = 5'd15;
            8'h7D: k = 5'd16;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction
endpackage

// ===== design/fct_core.sv =====
// Single-pass scanner: one character in, up to three tokens out, state update.
`timescale 1ns / 1ps
`default_nettype none
module fct_core #(
    parameter int MAX_LEN = fct_pkg::MaxTextLength,
    parameter int DEPTH   = fct_pkg::ScopeStackDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [7:0]     i_char,
    input  wire logic           i_last,
    input  wire logic [7:0]     i_arg_sep,
    input  wire logic [7:0]     i_row_sep,
    input  wire logic [7:0]     i_dec_sep,
    output fct_pkg::t_tok       o_tok [fct_pkg::ResultCount]
);
    import fct_pkg::*;
    localparam int DW = $clog2(DEPTH + 1);
    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PosW-1:0] MaxL = PosW'(MAX_LEN);
    localparam logic [PosW-1:0] MaxS = PosW'(MAX_LEN - 1);

    t_mode            r_mode, n_mode;
    logic [PosW-1:0]  r_pos, n_pos, r_ostart, n_ostart, r_olen, n_olen;
    logic             r_dec, n_dec, r_fault, n_fault;
    logic [15:0]      r_prev, n_prev;
    logic [DW-1:0]    r_depth, n_depth;
    logic [DEPTH-1:0] r_stack;
    logic             push_en, push_val;
    logic [SW-1:0]    push_idx;
    t_tok             tk [ResultCount];
    int               nt;

    function automatic logic [PosW-1:0] inc(input logic [PosW-1:0] v);
        return (v < MaxL) ? v + 1'b1 : MaxL;
    endfunction
    function automatic logic [PosW-1:0] sat(input logic [PosW-1:0] v);
        return (v > MaxS) ? MaxS : v;
    endfunction

    always_comb begin
        logic [7:0]       c;
        logic [KindW-1:0] k;
        logic             found, do_disp, ends_nm, closer_q;
        logic [PosW-1:0]  spos, epos;
        c = i_char;
        k = op_kind(c);
        spos = sat(r_pos);
        epos = sat(inc(r_pos));
        n_mode = r_mode; n_pos = r_pos; n_ostart = r_ostart; n_olen = r_olen;
        n_dec = r_dec; n_fault = r_fault; n_prev = r_prev; n_depth = r_depth;
        push_en = 1'b0; push_val = 1'b0; push_idx = '0;
        do_disp = 1'b0; found = 1'b0; closer_q = 1'b0;
        nt = 0;
        for (int i = 0; i < ResultCount; i++) begin
            tk[i] = '{vld: 1'b0, kind: K_NONE, start: '0, len: '0};
        end
        ends_nm = (c == i_arg_sep) || (k != '0) || (c == CH_SPACE) || (c == CH_DQUOTE);
        if (r_fault) begin
            if (i_last) begin
                n_mode = MODE_IDLE; n_pos = '0; n_ostart = '0; n_olen = '0;
                n_dec = 1'b0; n_prev = '0; n_depth = '0; n_fault = 1'b0;
            end
        end else begin
            // Name-character handling is repeated in name mode and for a numeral that turns into a name.
            case (r_mode)
                MODE_NUM: begin
                    if (c == CH_COLON || (c == i_dec_sep && r_dec && !is_digit(c))) begin
                        n_mode = MODE_NAME;
                        n_depth = '0;
                        if (c == CH_LBRK || c == CH_SQUOTE) begin
                            if (DEPTH < 1) begin
                                n_fault = 1'b1;
                            end else begin
                                push_en = 1'b1; push_idx = '0;
                                push_val = (c == CH_SQUOTE);
                                n_depth = DW'(1); n_olen = inc(r_olen);
                            end
                        end else if (ends_nm) begin
                            tk[0] = '{1'b1, K_NAME, r_ostart[StartW-1:0], r_olen};
                            nt = 1; n_mode = MODE_IDLE; do_disp = 1'b1;
                        end else begin
                            n_olen = inc(r_olen);
                        end
                    end else if (is_digit(c)) begin
                        n_olen = inc(r_olen);
                    end else if (c == i_dec_sep) begin
                        n_dec = 1'b1; n_olen = inc(r_olen);
                    end else begin
                        tk[0] = '{1'b1, K_NUMBER, r_ostart[StartW-1:0], r_olen};
                        nt = 1; n_mode = MODE_IDLE; do_disp = 1'b1;
                    end
                end
                MODE_NAME: begin
                    closer_q = r_stack[SW'(r_depth - 1'b1)];
                    if (r_depth != '0 && c == (closer_q ? CH_SQUOTE : CH_RBRK)) begin
                        n_depth = r_depth - 1'b1; n_olen = inc(r_olen);
                    end else if (c == CH_LBRK || c == CH_SQUOTE) begin
                        if (r_depth >= DW'(DEPTH)) begin
                            tk[0] = '{1'b1, K_OVERFLOW, r_ostart[StartW-1:0], inc(r_olen)};
                            nt = 1; n_fault = 1'b1;
                        end else begin
                            push_en = 1'b1; push_idx = SW'(r_depth);
                            push_val = (c == CH_SQUOTE);
                            n_depth = r_depth + 1'b1; n_olen = inc(r_olen);
                        end
                    end else if (r_depth == '0 && ends_nm) begin
                        tk[0] = '{1'b1, K_NAME, r_ostart[StartW-1:0], r_olen};
                        nt = 1; n_mode = MODE_IDLE; do_disp = 1'b1;
                    end else begin
                        n_olen = inc(r_olen);
                    end
                end
                MODE_STR: begin
                    if (c == CH_DQUOTE) begin
                        tk[0] = '{1'b1, K_STRING, r_ostart[StartW-1:0], r_olen};
                        nt = 1; n_mode = MODE_IDLE;
                    end else begin
                        n_olen = inc(r_olen);
                    end
                end
                MODE_ERR: begin
                    found = (c == CH_BANG) || (c == CH_QMARK) ||
                            (c == CH_A && r_olen == PosW'(3) && r_prev[7:0] == CH_SLASH &&
                             r_prev[15:8] == CH_N);
                    n_olen = inc(r_olen);
                    if (found) begin
                        tk[0] = '{1'b1, K_ERROR, r_ostart[StartW-1:0], n_olen};
                        nt = 1; n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE; do_disp = 1'b1;
                end
            endcase
            if (do_disp) begin
                if (is_digit(c)) begin
                    n_mode = MODE_NUM; n_ostart = spos; n_olen = PosW'(1); n_dec = 1'b0;
                end else if (k != '0) begin
                    tk[nt] = '{1'b1, k, spos[StartW-1:0], PosW'(1)}; nt = nt + 1;
                end else if (c == CH_SPACE) begin
                    n_mode = MODE_IDLE;
                end else if (c == CH_DQUOTE) begin
                    n_mode = MODE_STR; n_ostart = epos; n_olen = '0;
                end else if (c == CH_HASH) begin
                    n_mode = MODE_ERR; n_ostart = spos; n_olen = PosW'(1);
                end else if (c == i_arg_sep) begin
                    tk[nt] = '{1'b1, K_SEP, spos[StartW-1:0], PosW'(1)}; nt = nt + 1;
                end else if (c == i_row_sep) begin
                    tk[nt] = '{1'b1, K_ROWSEP, spos[StartW-1:0], PosW'(1)}; nt = nt + 1;
                end else begin
                    // Start a name; this byte cannot end it.
                    n_mode = MODE_NAME; n_ostart = spos; n_olen = '0; n_depth = '0;
                    if (c == CH_LBRK || c == CH_SQUOTE) begin
                        push_en = 1'b1; push_idx = '0; push_val = (c == CH_SQUOTE);
                        n_depth = DW'(1); n_olen = PosW'(1);
                    end else begin
                        n_olen = PosW'(1);
                    end
                end
            end
            if (i_last) begin
                if (!n_fault) begin
                    case (n_mode)
                        MODE_NUM: begin
                            tk[nt] = '{1'b1, K_NUMBER, n_ostart[StartW-1:0], n_olen}; nt = nt + 1;
                        end
                        MODE_NAME: begin
                            tk[nt] = '{1'b1, K_NAME, n_ostart[StartW-1:0], n_olen}; nt = nt + 1;
                        end
                        MODE_STR: begin
                            tk[nt] = '{1'b1, K_STRING, n_ostart[StartW-1:0], n_olen}; nt = nt + 1;
                        end
                        MODE_ERR: begin
                            tk[nt] = '{1'b1, K_BAD_ERROR, n_ostart[StartW-1:0], n_olen};
                            nt = nt + 1; n_fault = 1'b1;
                        end
                        default: ;
                    endcase
                    if (!n_fault) begin
                        tk[nt] = '{1'b1, K_END, epos[StartW-1:0], '0};
                        nt = nt + 1;
                    end
                end
                n_mode = MODE_IDLE; n_pos = '0; n_ostart = '0; n_olen = '0;
                n_dec = 1'b0; n_prev = '0; n_depth = '0; n_fault = 1'b0;
            end else begin
                n_pos = inc(r_pos);
                n_prev = {r_prev[7:0], c};
            end
        end
    end

    assign o_tok = tk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE; r_pos <= '0; r_ostart <= '0; r_olen <= '0;
            r_dec <= 1'b0; r_prev <= '0; r_depth <= '0; r_fault <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode; r_pos <= n_pos; r_ostart <= n_ostart; r_olen <= n_olen;
            r_dec <= n_dec; r_prev <= n_prev; r_depth <= n_depth; r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && push_en) begin
            r_stack[push_idx] <= push_val;
        end
    end
endmodule
`default_nettype wire

// ===== design/fct_outq.sv =====
// Output queue: takes up to three tokens per beat and hands them out one at a time.
`timescale 1ns / 1ps
`default_nettype none
module fct_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  fct_pkg::t_tok       i_tok [fct_pkg::ResultCount],
    input  wire logic           i_pop,
    output logic                o_room,
    output logic                o_valid,
    output fct_pkg::t_tok       o_head,
    output logic                o_last
);
    import fct_pkg::*;
    localparam int Depth = 8;
    typedef struct packed {
        t_tok tok;
        logic last;
    } t_ent;

    t_ent       r_mem [Depth];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] cnt_in;
    logic [2:0] wa [ResultCount];

    always_comb begin
        cnt_in = '0;
        for (int i = 0; i < ResultCount; i++) begin
            if (i_push && i_tok[i].vld) cnt_in = cnt_in + 1'b1;
        end
        for (int i = 0; i < ResultCount; i++) wa[i] = r_wp + 3'(i);
    end

    assign o_room  = r_cnt <= 4'(Depth - ResultCount);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp].tok;
    assign o_last  = r_mem[r_rp].last;
    assign n_cnt   = r_cnt + 4'(cnt_in) - 4'(i_pop && o_valid);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ResultCount; i++) begin
            if (i_push && i_tok[i].vld) begin
                r_mem[wa[i]] <= '{tok: i_tok[i],
                    last: (i == ResultCount - 1) ? 1'b1 : !i_tok[(i + 1) % ResultCount].vld};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + 3'(cnt_in);
            r_rp  <= r_rp + 3'(i_pop && o_valid);
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

// ===== design/formula_char_tokenizer.sv =====
// Top level of the formula character tokenizer.
`timescale 1ns / 1ps
`default_nettype none
// Formula character tokenizer: feed one formula byte per beat, flag the last byte
// with i_end_of_text, and take tokens (kind, start, length) from the output side.
// Every byte is scanned in the cycle it is accepted; a byte can be taken every
// cycle while the eight-entry result queue has room for three more tokens; with
// several tokens per byte the rate is set by the queue drain of one token per
// cycle while i_stall is low. o_run_last marks a byte's last token. The user must
// write separator registers via the config port while idle; the block won't check.
module formula_char_tokenizer #(
    parameter int MAX_TEXT_LENGTH   = fct_pkg::MaxTextLength,
    parameter int SCOPE_STACK_DEPTH = fct_pkg::ScopeStackDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [4:0]      o_token_kind,
    output logic [11:0]     o_token_start,
    output logic [12:0]     o_token_length,
    output logic            o_run_last,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import fct_pkg::*;
    `include "formula_char_tokenizer_assert.svh"

    logic [7:0] r_arg, r_row, r_dec;
    logic       step, room, pop;
    t_tok       toks [ResultCount];
    t_tok       head;

    // Accept a byte only while the queue can absorb a full burst.
    assign o_stall     = !room;
    assign step        = i_valid && room;
    assign o_cfg_ready = 1'b1;
    assign pop         = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arg <= 8'h2C; r_row <= 8'h3B; r_dec <= 8'h2E;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ARG: r_arg <= i_cfg_data;
                REG_ROW: r_row <= i_cfg_data;
                REG_DEC: r_dec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fct_core #(.MAX_LEN(MAX_TEXT_LENGTH), .DEPTH(SCOPE_STACK_DEPTH)) u_core (
        .i_clk, .i_rst_n, .i_step(step), .i_char(i_char_code), .i_last(i_end_of_text),
        .i_arg_sep(r_arg), .i_row_sep(r_row), .i_dec_sep(r_dec), .o_tok(toks)
    );

    fct_outq u_q (
        .i_clk, .i_rst_n, .i_push(step), .i_tok(toks), .i_pop(pop),
        .o_room(room), .o_valid, .o_head(head), .o_last(o_run_last)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.len;

    // A byte that yields a third token must have yielded the first two.
    `FCT_ASSERT_IMP(a_tok_order, i_clk, i_rst_n, toks[2].vld, toks[0].vld && toks[1].vld)
    // A stalled output keeps its token.
    `FCT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(head))
endmodule
`default_nettype wire

// ===== verif/tb_formula_char_tokenizer.sv =====
// Testbench for the formula character tokenizer: directed and random formulas, checked per token.
`timescale 1ns / 1ps
module tb_formula_char_tokenizer;
    import fct_pkg::*;

    localparam int MaxLen = MaxTextLength;

    typedef struct packed {
        logic [4:0]  kind;
        logic [11:0] start;
        logic [12:0] len;
        logic        last;
    } t_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_code;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_token_kind;
    logic [11:0] o_token_start;
    logic [12:0] o_token_length;
    logic        o_run_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    formula_char_tokenizer dut (.*);

    // Predictor state: a private copy of the scanner.
    logic [7:0]  sep_arg, sep_row, sep_dec;
    t_mode       mode;
    int unsigned pos, tok_start, tok_len, depth;
    logic        dec_seen, fault;
    logic [15:0] prev;
    logic        closers [ScopeStackDepth];

    t_token expected_tokens[$];
    t_token step_tokens[$];
    int     mismatches;
    int     sent;
    int     burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: stall on its own pattern, with quiet stretches.
    int stall_phase;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase / 200) % 3 == 2) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Compare each accepted token with the oldest expectation.
    always @(posedge i_clk) begin
        t_token exp_tok;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected token kind=%0d start=%0d len=%0d last=%0b",
                             o_token_kind, o_token_start, o_token_length, o_run_last);
                end
            end else begin
                exp_tok = expected_tokens.pop_front();
                if (exp_tok.kind !== o_token_kind || exp_tok.start !== o_token_start ||
                    exp_tok.len !== o_token_length || exp_tok.last !== o_run_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("token mismatch exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 exp_tok.kind, exp_tok.start, exp_tok.len, exp_tok.last,
                                 o_token_kind, o_token_start, o_token_length, o_run_last);
                    end
                end
            end
        end
    end

    function automatic int unsigned bump(int unsigned v);
        return (v < MaxLen) ? v + 1 : MaxLen;
    endfunction

    function automatic int unsigned clip_start(int unsigned v);
        return (v > MaxLen - 1) ? MaxLen - 1 : v;
    endfunction

    function automatic logic [4:0] oper_code(logic [7:0] c);
        case (c)
            "&": return 5'd4;
            "(": return 5'd5;
            ")": return 5'd6;
            "*": return 5'd7;
            "+": return 5'd8;
            "-": return 5'd9;
            "/": return 5'd10;
            "<": return 5'd11;
            "=": return 5'd12;
            ">": return 5'd13;
            "^": return 5'd14;
            "{": return 5'd15;
            "}": return 5'd16;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void push_token(logic [4:0] k, int unsigned s, int unsigned l);
        t_token t;
        t.kind  = k;
        t.start = clip_start(s);
        t.len   = (l > MaxLen) ? MaxLen : l;
        t.last  = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void clear_scan();
        mode = MODE_IDLE;
        pos = 0; tok_start = 0; tok_len = 0; depth = 0;
        dec_seen = 1'b0; prev = '0; fault = 1'b0;
    endfunction

    // Take one byte inside a name; return 1 when the name closed before it.
    function automatic logic name_byte(logic [7:0] c);
        logic [7:0] closer;
        if (depth > 0) begin
            closer = closers[depth-1] ? CH_SQUOTE : CH_RBRK;
            if (c == closer) begin
                depth--;
                tok_len = bump(tok_len);
                return 1'b0;
            end
        end
        if (c == CH_LBRK || c == CH_SQUOTE) begin
            if (depth >= ScopeStackDepth) begin
                push_token(K_OVERFLOW, tok_start, bump(tok_len));
                fault = 1'b1;
                return 1'b0;
            end
            closers[depth] = (c == CH_SQUOTE);
            depth++;
            tok_len = bump(tok_len);
            return 1'b0;
        end
        if (depth == 0 && (c == sep_arg || oper_code(c) != K_NONE ||
                           c == CH_SPACE || c == CH_DQUOTE)) begin
            push_token(K_NAME, tok_start, tok_len);
            mode = MODE_IDLE;
            return 1'b1;
        end
        tok_len = bump(tok_len);
        return 1'b0;
    endfunction

    // Start a new token (or emit a one-byte one) from idle.
    function automatic void start_token(logic [7:0] c);
        logic [4:0] k;
        k = oper_code(c);
        if (is_num(c)) begin
            mode = MODE_NUM; tok_start = clip_start(pos); tok_len = 1; dec_seen = 1'b0;
        end else if (k != K_NONE) begin
            push_token(k, pos, 1);
        end else if (c == CH_SPACE) begin
        end else if (c == CH_DQUOTE) begin
            mode = MODE_STR; tok_start = clip_start(bump(pos)); tok_len = 0;
        end else if (c == CH_HASH) begin
            mode = MODE_ERR; tok_start = clip_start(pos); tok_len = 1;
        end else if (c == sep_arg) begin
            push_token(K_SEP, pos, 1);
        end else if (c == sep_row) begin
            push_token(K_ROWSEP, pos, 1);
        end else begin
            mode = MODE_NAME; tok_start = clip_start(pos); tok_len = 0; depth = 0;
            void'(name_byte(c));
        end
    endfunction

    // Predict the tokens one accepted byte causes and queue them.
    function automatic void predict_tokens(logic [7:0] c, logic eot);
        logic hit;
        step_tokens.delete();
        if (fault) begin
            if (eot) clear_scan();
            return;
        end
        case (mode)
            MODE_NUM: begin
                if (c == CH_COLON || (c == sep_dec && dec_seen && !is_num(c))) begin
                    mode = MODE_NAME; depth = 0;
                    if (name_byte(c)) start_token(c);
                end else if (is_num(c)) begin
                    tok_len = bump(tok_len);
                end else if (c == sep_dec) begin
                    dec_seen = 1'b1; tok_len = bump(tok_len);
                end else begin
                    push_token(K_NUMBER, tok_start, tok_len);
                    mode = MODE_IDLE;
                    start_token(c);
                end
            end
            MODE_NAME: if (name_byte(c)) start_token(c);
            MODE_STR: begin
                if (c == CH_DQUOTE) begin
                    push_token(K_STRING, tok_start, tok_len);
                    mode = MODE_IDLE;
                end else begin
                    tok_len = bump(tok_len);
                end
            end
            MODE_ERR: begin
                hit = (c == CH_BANG || c == CH_QMARK);
                if (c == CH_A && tok_len == 3 && prev[7:0] == CH_SLASH && prev[15:8] == CH_N)
                    hit = 1'b1;
                tok_len = bump(tok_len);
                if (hit) begin
                    push_token(K_ERROR, tok_start, tok_len);
                    mode = MODE_IDLE;
                end
            end
            default: begin
                mode = MODE_IDLE;
                start_token(c);
            end
        endcase
        if (eot) begin
            if (!fault) begin
                case (mode)
                    MODE_NUM:  push_token(K_NUMBER, tok_start, tok_len);
                    MODE_NAME: push_token(K_NAME, tok_start, tok_len);
                    MODE_STR:  push_token(K_STRING, tok_start, tok_len);
                    MODE_ERR: begin
                        push_token(K_BAD_ERROR, tok_start, tok_len);
                        fault = 1'b1;
                    end
                    default: ;
                endcase
                if (!fault) push_token(K_END, bump(pos), 0);
            end
            clear_scan();
        end else begin
            pos  = bump(pos);
            prev = {prev[7:0], c};
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // Send one byte as a beat; gaps come between bursts of random length.
    // Valid stays high after the beat so the next byte can follow at once; a gap or drain drops it.
    task automatic send_char(logic [7:0] c, logic eot = 1'b0);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_char_code   <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_tokens(c, eot);
        sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_char(s[i], i == s.len() - 1);
    endtask

    // Hold until every expected token is out and the block has settled.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_ARG: sep_arg = val;
            REG_ROW: sep_row = val;
            default: sep_dec = val;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_text("=SUM(A1:B2,3.5)&\"ab\"");
        send_text("1.2.3+#N/A-#DIV/0!*#REF?");
        send_text("12:34 'a b'!C1;[x]y^{1;2}<>/");
        send_text("#VALUE");
        send_text("\"open");
        send_text("x[[[[[[[[[[[[[[[[[zz");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        drain();
    endtask

    // Mostly well-formed formula pieces with random content, plus raw noise.
    task automatic test_random(int count);
        string pieces[] = '{"12", "3.25", "A1", "foo", "\"s t\"", "#N/A", "#NUM!",
                            "[a]", "'q''r'", "+", "(", ")", " ", ",", ";", ":", "^",
                            "#X?", "7..1", "}", "{", "=", "<", ">", "*", "/", "-", "&"};
        string s;
        int    n, k;
        n = 0;
        while (n < count) begin
            s = "";
            k = $urandom_range(1, 8);
            repeat (k) begin
                if ($urandom_range(0, 4) == 0) s = {s, string'(byte'($urandom_range(0, 255)))};
                else s = {s, pieces[$urandom_range(0, pieces.size() - 1)]};
            end
            if (s.len() == 0) s = "0";
            send_text(s);
            n += s.len();
        end
        drain();
    endtask

    task automatic test_separators();
        write_reg(REG_ARG, 8'h3B);
        write_reg(REG_ROW, 8'h2C);
        write_reg(REG_DEC, 8'h2C);
        repeat (20) @(posedge i_clk);
        send_text("1,5,6;2 x;y");
        test_random(20);
        write_reg(REG_ARG, 8'h00);
        write_reg(REG_ROW, 8'hFF);
        write_reg(REG_DEC, 8'h3A);
        send_text("1:2");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        test_random(20);
        write_reg(REG_ARG, 8'hFF);
        write_reg(REG_ROW, 8'h00);
        write_reg(REG_DEC, 8'h5B);
        send_text("1[2[3");
        test_random(20);
        write_reg(REG_ARG, 8'h2C);
        write_reg(REG_ROW, 8'h3B);
        write_reg(REG_DEC, 8'h2E);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_char_code = '0; i_end_of_text = 1'b0;
        i_stall = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        stall_phase = 0; mismatches = 0; sent = 0; burst_left = 0;
        sep_arg = 8'h2C; sep_row = 8'h3B; sep_dec = 8'h2E;
        foreach (closers[i]) closers[i] = 1'b0;
        clear_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(60);
        test_separators();
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
